// ===== rtl/core/cmap4_pkg.sv =====
// ----------------------------------------------------------------------------
// cmap4_pkg
// Shared types and constants of the format-4 character map lookup block.
// ----------------------------------------------------------------------------
package cmap4_pkg;

  localparam int MAX_SEGMENTS      = 256;
  localparam int GLYPH_ARRAY_DEPTH = 1024;

  localparam int SEG_AW    = $clog2(MAX_SEGMENTS);
  localparam int GLY_AW    = $clog2(GLYPH_ARRAY_DEPTH);
  localparam int SEG_CNT_W = 9;
  localparam int SLOT_W    = 10;
  localparam int CMD_W     = 2;
  localparam int WORD_W    = 16;
  localparam int CODE_W    = 21;
  localparam int OFFS_W    = WORD_W + 1;
  localparam int POS_W     = OFFS_W + 1;
  localparam int SEG_REC_W = 4 * WORD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEGMENT = 2'd0,
    CMD_GLYPH   = 2'd1,
    CMD_LOOKUP  = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_GLYPH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] seg_start;
    logic [WORD_W-1:0] seg_end;
    logic [WORD_W-1:0] seg_delta;
    logic [WORD_W-1:0] seg_range_offset;
  } seg_rec_t;

endpackage

// ===== rtl/core/cmap4_if.sv =====
// ----------------------------------------------------------------------------
// cmap4_if
// Valid/ready channels for requests and results of the character map lookup.
// ----------------------------------------------------------------------------
interface cmap4_req_if;
  import cmap4_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [WORD_W-1:0] seg_start;
  logic [WORD_W-1:0] seg_end;
  logic [WORD_W-1:0] seg_delta;
  logic [WORD_W-1:0] seg_range_offset;
  logic [WORD_W-1:0] glyph_word;
  logic [CODE_W-1:0] code_point;

  modport source (
    output valid, command, slot, seg_start, seg_end, seg_delta,
           seg_range_offset, glyph_word, code_point,
    input  ready
  );

  modport sink (
    input  valid, command, slot, seg_start, seg_end, seg_delta,
           seg_range_offset, glyph_word, code_point,
    output ready
  );
endinterface

interface cmap4_res_if;
  import cmap4_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] glyph_id;
  logic              matched;
  logic              array_fault;

  modport source (
    output valid, glyph_id, matched, array_fault,
    input  ready
  );

  modport sink (
    input  valid, glyph_id, matched, array_fault,
    output ready
  );
endinterface

// ===== rtl/core/cmap4_ram.sv =====
// ----------------------------------------------------------------------------
// cmap4_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cmap4_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cmap_format4_glyph_lookup.sv =====
// ----------------------------------------------------------------------------
// cmap_format4_glyph_lookup
// Character code to glyph index translation with a format-4 character map.
//
// Usage: requests arrive on req. A segment request stores start, end, delta
// and range offset at the given slot; a glyph request stores one word of the
// glyph id array. Both give no result. A lookup request scans the loaded
// segments in order, one segment read from the segment RAM per cycle, and
// returns one result on res: glyph index, matched flag and array fault flag.
// A code above 65535 skips the scan. req.ready is low while a lookup is in
// progress, so lookups run one at a time.
// Results sit in an output register; the next request is taken while a
// result waits. A lookup that finishes while the receiver still stalls holds
// in its final state until the output register frees up.
// cfg_wen/cfg_wdata write the segment count; the user writes it only while
// the block is idle, which the block itself does not enforce.
// Reset clears the segment count and all control state; the RAMs are not
// cleared and read back only what was written.
// ----------------------------------------------------------------------------
module cmap_format4_glyph_lookup
  import cmap4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [SEG_CNT_W-1:0] cfg_wdata,
  cmap4_req_if.sink            req,
  cmap4_res_if.source          res
);

  state_t state, state_next;

  logic [SEG_CNT_W-1:0] seg_cnt;
  logic [SEG_CNT_W-1:0] nseg;
  logic [WORD_W-1:0]    code;
  logic [SEG_CNT_W-1:0] seg_addr;
  logic                 chk_valid;
  logic [SEG_AW-1:0]    chk_idx;
  logic [SEG_AW-1:0]    hit_idx;
  logic [OFFS_W-1:0]    offs;
  logic [WORD_W-1:0]    delta;
  logic                 range_zero;
  logic [WORD_W-1:0]    res_glyph;
  logic                 res_matched;
  logic                 res_fault;
  logic                 out_valid;
  logic [WORD_W-1:0]    out_glyph;
  logic                 out_matched;
  logic                 out_fault;

  logic                 req_fire;
  logic                 code_big;
  logic                 seg_we;
  logic                 gly_we;
  seg_rec_t             seg_wrec;
  seg_rec_t             seg_rrec;
  logic [WORD_W-1:0]    gly_rdata;
  logic                 hit;
  logic                 issue;
  logic [POS_W-1:0]     pos;
  logic                 pos_fault;
  logic                 out_free;

  assign req_fire = req.valid && req.ready;
  assign code_big = |req.code_point[CODE_W-1:WORD_W];
  assign out_free = !out_valid || res.ready;

  assign seg_we = req_fire && (req.command == CMD_SEGMENT) &&
                  ({1'b0, req.slot} < (SLOT_W + 1)'(MAX_SEGMENTS));
  assign gly_we = req_fire && (req.command == CMD_GLYPH) &&
                  ({1'b0, req.slot} < (SLOT_W + 1)'(GLYPH_ARRAY_DEPTH));

  assign seg_wrec = '{seg_start:        req.seg_start,
                      seg_end:          req.seg_end,
                      seg_delta:        req.seg_delta,
                      seg_range_offset: req.seg_range_offset};

  cmap4_ram #(
    .WIDTH (SEG_REC_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (req.slot[SEG_AW-1:0]),
    .wdata (seg_wrec),
    .raddr (seg_addr[SEG_AW-1:0]),
    .rdata (seg_rrec)
  );

  cmap4_ram #(
    .WIDTH (WORD_W),
    .DEPTH (GLYPH_ARRAY_DEPTH)
  ) u_gly_ram (
    .clk   (clk),
    .we    (gly_we),
    .waddr (req.slot[GLY_AW-1:0]),
    .wdata (req.glyph_word),
    .raddr (pos[GLY_AW-1:0]),
    .rdata (gly_rdata)
  );

  // segment compare and glyph array position
  assign hit   = chk_valid && (code >= seg_rrec.seg_start) && (code <= seg_rrec.seg_end);
  assign issue = seg_addr < nseg;
  assign pos   = POS_W'(offs) + POS_W'(hit_idx) - POS_W'(nseg);
  assign pos_fault = pos[POS_W-1] ||
                     (pos[POS_W-2:0] >= (POS_W - 1)'(GLYPH_ARRAY_DEPTH));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && (req.command == CMD_LOOKUP)) begin
          state_next = code_big ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_CALC;
        end else if (!issue && !chk_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_CALC: begin
        state_next = (range_zero || pos_fault) ? ST_FINISH : ST_GLYPH;
      end
      ST_GLYPH: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready       = (state == ST_IDLE);
    res.valid       = out_valid;
    res.glyph_id    = out_glyph;
    res.matched     = out_matched;
    res.array_fault = out_fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_cnt   <= '0;
      out_valid <= 1'b0;
      chk_valid <= 1'b0;
      seg_addr  <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        seg_cnt <= cfg_wdata;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          seg_addr  <= '0;
          chk_valid <= 1'b0;
        end
        ST_SCAN: begin
          if (!hit) begin
            seg_addr  <= seg_addr + SEG_CNT_W'(issue);
            chk_valid <= issue;
          end
        end
        default: begin
          chk_valid <= 1'b0;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        code        <= req.code_point[WORD_W-1:0];
        nseg        <= (seg_cnt > SEG_CNT_W'(MAX_SEGMENTS)) ?
                       SEG_CNT_W'(MAX_SEGMENTS) : seg_cnt;
        res_glyph   <= '0;
        res_matched <= 1'b0;
        res_fault   <= 1'b0;
      end
      ST_SCAN: begin
        chk_idx <= seg_addr[SEG_AW-1:0];
        if (hit) begin
          offs       <= OFFS_W'(seg_rrec.seg_range_offset[WORD_W-1:1]) +
                        OFFS_W'(code - seg_rrec.seg_start);
          delta      <= seg_rrec.seg_delta;
          range_zero <= (seg_rrec.seg_range_offset == '0);
          hit_idx    <= chk_idx;
        end
      end
      ST_CALC: begin
        res_matched <= 1'b1;
        if (range_zero) begin
          res_glyph <= code + delta;
        end else if (pos_fault) begin
          res_fault <= 1'b1;
        end
      end
      ST_GLYPH: begin
        res_glyph <= (gly_rdata == '0) ? '0 : gly_rdata + delta;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_glyph   <= res_glyph;
          out_matched <= res_matched;
          out_fault   <= res_fault;
        end
      end
      default: begin
        res_fault <= 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/cmap4_checker.sv =====
// ----------------------------------------------------------------------------
// cmap4_checker
// Port-level checks of the character map lookup, bound to the top level.
// ----------------------------------------------------------------------------
module cmap4_checker
  import cmap4_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic [CMD_W-1:0]  req_command,
  input logic              res_valid,
  input logic              res_ready,
  input logic [WORD_W-1:0] glyph_id,
  input logic              matched,
  input logic              array_fault
);

  // a lookup keeps the request side closed on the next cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_command == CMD_LOOKUP) |=> !req_ready)
    else $error("request taken right after a lookup");

  // store writes never close the request side
  a_write_open: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_command != CMD_LOOKUP) |=> req_ready)
    else $error("request side closed after a store write");

  // a result with no match carries the missing glyph and no fault
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !matched) |-> (glyph_id == '0 && !array_fault))
    else $error("unmatched result with glyph or fault");

  // a fault implies a matched segment and the missing glyph
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && array_fault) |-> (matched && glyph_id == '0))
    else $error("fault result with glyph or without match");

  // a stalled result stays
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped under stall");

endmodule

bind cmap_format4_glyph_lookup cmap4_checker u_cmap4_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_command (req.command),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .glyph_id    (res.glyph_id),
  .matched     (res.matched),
  .array_fault (res.array_fault)
);

// ===== verif/cmap_format4_glyph_lookup_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cmap_format4_glyph_lookup_test
// Self-checking bench for the format-4 character map lookup. It loads segment
// tables and glyph id words, runs lookups and compares each result with its
// own copy of the map. Directed cases cover delta wraparound, range offsets,
// faults and ignored requests. Random phases load sorted font-like tables
// under several segment counts, with some noisy tables mixed in.
// ----------------------------------------------------------------------------
module cmap_format4_glyph_lookup_test;
  import cmap4_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int SETTLE_CYCLES = MAX_SEGMENTS + 10;
  localparam int MAX_WAIT      = 19;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    seg_rec_t          seg;
    logic [WORD_W-1:0] glyph_word;
    logic [CODE_W-1:0] code_point;
  } request_t;

  typedef struct packed {
    logic [WORD_W-1:0] glyph_id;
    logic              matched;
    logic              array_fault;
  } glyph_result_t;

  typedef enum {ENTRY_READY, ENTRY_SEGMENT, ENTRY_GLYPH} missing_entry_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wen;
  logic [SEG_CNT_W-1:0] cfg_wdata;

  cmap4_req_if req_ch();
  cmap4_res_if res_ch();

  cmap_format4_glyph_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  seg_rec_t          seg_table    [MAX_SEGMENTS];
  bit                seg_loaded   [MAX_SEGMENTS];
  logic [WORD_W-1:0] glyph_table  [GLYPH_ARRAY_DEPTH];
  bit                glyph_loaded [GLYPH_ARRAY_DEPTH];
  int                seg_count_cfg = 0;
  glyph_result_t     pending_glyphs[$];

  bit req_pacing = 1'b1;
  bit res_pacing = 1'b1;
  int mismatches   = 0;
  int items_sent   = 0;
  int table_writes = 0;
  int lookups_done = 0;
  int matches_seen = 0;
  int faults_seen  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int scanned_segments();
    return (seg_count_cfg > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count_cfg;
  endfunction

  function automatic int glyph_position(input int s, input int n,
                                        input logic [WORD_W-1:0] code);
    return s + int'(seg_table[s].seg_range_offset >> 1) + int'(code)
         - int'(seg_table[s].seg_start) - n;
  endfunction

  function automatic glyph_result_t translate_code(input logic [CODE_W-1:0] code);
    glyph_result_t r;
    int n;
    int pos;
    r = '0;
    if (code > CODE_W'(16'hFFFF)) return r;
    n = scanned_segments();
    for (int s = 0; s < n; s++) begin
      if (code[WORD_W-1:0] >= seg_table[s].seg_start &&
          code[WORD_W-1:0] <= seg_table[s].seg_end &&
          code[CODE_W-1:WORD_W] == '0) begin
        r.matched = 1'b1;
        if (seg_table[s].seg_range_offset == '0) begin
          r.glyph_id = code[WORD_W-1:0] + seg_table[s].seg_delta;
        end else begin
          pos = glyph_position(s, n, code[WORD_W-1:0]);
          if (pos < 0 || pos >= GLYPH_ARRAY_DEPTH) begin
            r.array_fault = 1'b1;
          end else if (glyph_table[pos] != '0) begin
            r.glyph_id = glyph_table[pos] + seg_table[s].seg_delta;
          end
        end
        return r;
      end
    end
    return r;
  endfunction

  // first store entry a lookup of this code would read before it is written
  function automatic missing_entry_t find_unloaded(input logic [CODE_W-1:0] code,
                                                   output int idx);
    int n;
    int pos;
    idx = 0;
    if (code > CODE_W'(16'hFFFF)) return ENTRY_READY;
    n = scanned_segments();
    for (int s = 0; s < n; s++) begin
      if (!seg_loaded[s]) begin
        idx = s;
        return ENTRY_SEGMENT;
      end
      if (code[WORD_W-1:0] >= seg_table[s].seg_start &&
          code[WORD_W-1:0] <= seg_table[s].seg_end) begin
        if (seg_table[s].seg_range_offset != '0) begin
          pos = glyph_position(s, n, code[WORD_W-1:0]);
          if (pos >= 0 && pos < GLYPH_ARRAY_DEPTH && !glyph_loaded[pos]) begin
            idx = pos;
            return ENTRY_GLYPH;
          end
        end
        return ENTRY_READY;
      end
    end
    return ENTRY_READY;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    return WORD_W'($urandom());
  endfunction

  function automatic logic [WORD_W-1:0] random_glyph_word();
    return ($urandom_range(0, 3) == 0) ? '0 : random_word();
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.command              = CMD_W'($urandom());
    r.slot                 = SLOT_W'($urandom());
    r.seg.seg_start        = random_word();
    r.seg.seg_end          = random_word();
    r.seg.seg_delta        = random_word();
    r.seg.seg_range_offset = random_word();
    r.glyph_word           = random_word();
    r.code_point           = CODE_W'($urandom());
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(input int n);
    int s;
    case ($urandom_range(0, 19))
      0: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return CODE_W'(16'hFFFF);
          2: return CODE_W'(17'h10000);
          default: return '1;
        endcase
      end
      1, 2: return CODE_W'($urandom_range(32'h1FFFFF, 32'h10000));
      3, 4, 5: return CODE_W'($urandom_range(0, 16'hFFFF));
      default: begin
        if (n > 0) begin
          s = $urandom_range(0, n - 1);
          if (seg_loaded[s] && seg_table[s].seg_end >= seg_table[s].seg_start)
            return CODE_W'($urandom_range(seg_table[s].seg_end, seg_table[s].seg_start));
        end
        return CODE_W'($urandom_range(0, 16'hFFFF));
      end
    endcase
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    gap = req_pacing ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.command          <= r.command;
    req_ch.slot             <= r.slot;
    req_ch.seg_start        <= r.seg.seg_start;
    req_ch.seg_end          <= r.seg.seg_end;
    req_ch.seg_delta        <= r.seg.seg_delta;
    req_ch.seg_range_offset <= r.seg.seg_range_offset;
    req_ch.glyph_word       <= r.glyph_word;
    req_ch.code_point       <= r.code_point;
    do @(posedge clk); while (!req_ch.ready);
    case (r.command)
      CMD_SEGMENT: begin
        if (r.slot < MAX_SEGMENTS) begin
          seg_table[r.slot]  = r.seg;
          seg_loaded[r.slot] = 1'b1;
          items_sent++;
          table_writes++;
        end
      end
      CMD_GLYPH: begin
        if (r.slot < GLYPH_ARRAY_DEPTH) begin
          glyph_table[r.slot]  = r.glyph_word;
          glyph_loaded[r.slot] = 1'b1;
          items_sent++;
          table_writes++;
        end
      end
      CMD_LOOKUP: begin
        pending_glyphs.push_back(translate_code(r.code_point));
        items_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic write_segment(input int slot, input logic [WORD_W-1:0] lo,
                               input logic [WORD_W-1:0] hi,
                               input logic [WORD_W-1:0] delta,
                               input logic [WORD_W-1:0] offs);
    request_t r;
    r = random_request();
    r.command              = CMD_SEGMENT;
    r.slot                 = SLOT_W'(slot);
    r.seg.seg_start        = lo;
    r.seg.seg_end          = hi;
    r.seg.seg_delta        = delta;
    r.seg.seg_range_offset = offs;
    send_request(r);
  endtask

  task automatic write_noise_segment(input int slot);
    logic [WORD_W-1:0] lo;
    lo = random_word();
    write_segment(slot, lo,
                  ($urandom_range(0, 3) == 0) ? random_word()
                                              : WORD_W'(lo + $urandom_range(0, 2000)),
                  random_word(), $urandom_range(0, 1) ? '0 : random_word());
  endtask

  task automatic write_glyph(input int slot, input logic [WORD_W-1:0] word);
    request_t r;
    r = random_request();
    r.command    = CMD_GLYPH;
    r.slot       = SLOT_W'(slot);
    r.glyph_word = word;
    send_request(r);
  endtask

  task automatic send_ignored();
    request_t r;
    r = random_request();
    if ($urandom_range(0, 1)) begin
      r.command = CMD_SPARE;
    end else begin
      r.command = CMD_SEGMENT;
      r.slot    = SLOT_W'($urandom_range(MAX_SEGMENTS, 1023));
    end
    send_request(r);
  endtask

  // load whatever the scan would touch unwritten, then issue the lookup
  task automatic lookup_code(input logic [CODE_W-1:0] code);
    request_t r;
    missing_entry_t hole;
    int idx;
    hole = find_unloaded(code, idx);
    while (hole != ENTRY_READY) begin
      if (hole == ENTRY_SEGMENT) write_noise_segment(idx);
      else write_glyph(idx, random_glyph_word());
      hole = find_unloaded(code, idx);
    end
    r = random_request();
    r.command    = CMD_LOOKUP;
    r.code_point = code;
    send_request(r);
  endtask

  task automatic set_segment_count(input int value);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= SEG_CNT_W'(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
    seg_count_cfg = value;
  endtask

  // sorted segments, one per slice of the code space, like a real font
  task automatic load_font_table(input int count);
    int n, span, len, len_max, base;
    logic [WORD_W-1:0] lo, delta, offs;
    set_segment_count(count);
    n = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;
    if (n == 0) return;
    span = 65536 / n;
    len_max = (span / 2 - 1 > 300) ? 300 : span / 2 - 1;
    for (int s = 0; s < n; s++) begin
      if (s == n - 1 && $urandom_range(0, 1)) begin
        write_segment(s, 16'hFFFF, 16'hFFFF, 16'd1, '0);
      end else begin
        len   = $urandom_range(0, len_max);
        lo    = WORD_W'(s * span + $urandom_range(0, span - 1 - len));
        delta = random_word();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: offs = '0;
          9: offs = random_word();
          default: begin
            base = $urandom_range(0, GLYPH_ARRAY_DEPTH - 1 - len);
            offs = WORD_W'(2 * (base + n - s) + $urandom_range(0, 1));
          end
        endcase
        write_segment(s, lo, WORD_W'(lo + len), delta, offs);
      end
    end
  endtask

  task automatic load_noise_table(input int count);
    int n;
    set_segment_count(count);
    n = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 3) == 0)
        write_glyph($urandom_range(0, GLYPH_ARRAY_DEPTH - 1), random_glyph_word());
      else
        write_noise_segment((n > 0) ? $urandom_range(0, n - 1) : 0);
    end
  endtask

  task automatic test_reset_state();
    lookup_code(CODE_W'(16'h0041));
    lookup_code('1);
  endtask

  task automatic test_delta_segments();
    set_segment_count(4);
    write_segment(0, 16'h0000, 16'h0000, 16'hFFFF, '0);
    write_segment(1, 16'h0020, 16'h007E, 16'hFFE3, '0);
    write_segment(2, 16'h0040, 16'h0050, 16'h0005, '0);
    write_segment(3, 16'hFFFF, 16'hFFFF, 16'h0001, '0);
    lookup_code(CODE_W'(16'h0000));
    lookup_code(CODE_W'(16'h0041));
    lookup_code(CODE_W'(16'h007F));
    lookup_code(CODE_W'(16'hFFFF));
    lookup_code(CODE_W'(17'h10000));
    lookup_code('1);
  endtask

  task automatic test_glyph_ranges();
    set_segment_count(3);
    write_segment(0, 16'h0100, 16'h010F, 16'h0010, 16'd6);
    write_segment(1, 16'h0200, 16'h02FF, 16'h0000, 16'd1);
    write_segment(2, 16'h0400, 16'h07FF, 16'hF000, 16'd2042);
    write_glyph(0, 16'h1234);
    write_glyph(1, 16'h0000);
    write_glyph(GLYPH_ARRAY_DEPTH - 1, 16'hFFFF);
    send_ignored();
    send_ignored();
    lookup_code(CODE_W'(16'h0100));
    lookup_code(CODE_W'(16'h0101));
    lookup_code(CODE_W'(16'h0200));
    lookup_code(CODE_W'(16'h0202));
    lookup_code(CODE_W'(16'h0403));
    lookup_code(CODE_W'(16'h0404));
  endtask

  task automatic test_random_tables();
    int extremes[5] = '{0, 1, MAX_SEGMENTS, 511, MAX_SEGMENTS + 1};
    int phase, count, n;
    phase = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      req_pacing = ($urandom_range(0, 4) != 0);
      res_pacing = ($urandom_range(0, 4) != 0);
      if (phase < 5) count = extremes[phase];
      else if ($urandom_range(0, 7) == 0) count = $urandom_range(0, 511);
      else count = $urandom_range(1, 24);
      if (phase >= 5 && $urandom_range(0, 3) == 0) load_noise_table(count);
      else load_font_table(count);
      n = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;
      repeat ($urandom_range(20, 60)) begin
        case ($urandom_range(0, 15))
          0: write_glyph($urandom_range(0, GLYPH_ARRAY_DEPTH - 1), random_glyph_word());
          1: send_ignored();
          default: lookup_code(pick_code(n));
        endcase
      end
      phase++;
    end
  endtask

  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = res_pacing ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    glyph_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_glyphs.size() == 0) begin
        $error("result with no lookup pending");
        mismatches++;
      end else begin
        want = pending_glyphs.pop_front();
        lookups_done++;
        matches_seen += want.matched;
        faults_seen  += want.array_fault;
        if (res_ch.glyph_id !== want.glyph_id) begin
          $error("glyph_id: expected %h, got %h", want.glyph_id, res_ch.glyph_id);
          mismatches++;
        end
        if (res_ch.matched !== want.matched) begin
          $error("matched: expected %b, got %b", want.matched, res_ch.matched);
          mismatches++;
        end
        if (res_ch.array_fault !== want.array_fault) begin
          $error("array_fault: expected %b, got %b", want.array_fault, res_ch.array_fault);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #48_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst                     = 1'b1;
    cfg_wen                 = 1'b0;
    cfg_wdata               = '0;
    req_ch.valid            = 1'b0;
    req_ch.command          = '0;
    req_ch.slot             = '0;
    req_ch.seg_start        = '0;
    req_ch.seg_end          = '0;
    req_ch.seg_delta        = '0;
    req_ch.seg_range_offset = '0;
    req_ch.glyph_word       = '0;
    req_ch.code_point       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_delta_segments();
    test_glyph_ranges();
    test_random_tables();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d lookups (%0d matched, %0d array faults), %0d table writes",
             lookups_done, matches_seen, faults_seen, table_writes);
    $display("segment counts ran from 0 to 511, font-like and noisy tables mixed");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
